/* rtl/websocket_frame_decoder_assert.svh */
// Assertion macros used by the frame decoder parser module.
`ifndef WEBSOCKET_FRAME_DECODER_ASSERT_SVH
`define WEBSOCKET_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define WSFD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define WSFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/wsfd_pkg.sv */
`timescale 1ns / 1ps

package wsfd_pkg;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_KEY     = 3'd3,
        PH_PAYLOAD = 3'd4
    } t_phase;

    localparam logic [6:0] LenExt16     = 7'h7e;
    localparam logic [6:0] LenExt64     = 7'h7f;
    localparam logic [3:0] FieldsExt16  = 4'd2;
    localparam logic [3:0] FieldsExt64  = 4'd8;
    localparam logic [3:0] FieldsKey    = 4'd4;
    localparam logic       KindHeader   = 1'b0;
    localparam logic       KindPayload  = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_out;
        logic        fin;
        logic [2:0]  rsv_bits;
        logic [3:0]  opcode;
        logic        masked;
        logic [63:0] frame_length;
        logic        last;
    } t_result;

endpackage

/* rtl/wsfd_parser.sv */
`timescale 1ns / 1ps
`include "websocket_frame_decoder_assert.svh"

module wsfd_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    output logic             o_res_vld,
    output wsfd_pkg::t_result o_res
);

    wsfd_pkg::t_phase r_phase, n_phase;
    logic [3:0]  r_field_count, n_field_count;
    logic [63:0] r_length_acc, n_length_acc;
    logic [31:0] r_key_store, n_key_store;
    logic [63:0] r_remaining, n_remaining;
    logic [1:0]  r_key_index, n_key_index;
    logic        r_fin, n_fin;
    logic [2:0]  r_rsv, n_rsv;
    logic [3:0]  r_opcode, n_opcode;
    logic        r_masked, n_masked;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= wsfd_pkg::PH_HDR0;
            r_field_count <= '0;
            r_length_acc  <= '0;
            r_key_store   <= '0;
            r_remaining   <= '0;
            r_key_index   <= '0;
            r_fin         <= 1'b0;
            r_rsv         <= '0;
            r_opcode      <= '0;
            r_masked      <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_field_count <= n_field_count;
            r_length_acc  <= n_length_acc;
            r_key_store   <= n_key_store;
            r_remaining   <= n_remaining;
            r_key_index   <= n_key_index;
            r_fin         <= n_fin;
            r_rsv         <= n_rsv;
            r_opcode      <= n_opcode;
            r_masked      <= n_masked;
        end
    end

    always_comb begin
        logic       do_after;
        logic       do_hdr;
        logic [7:0] key_byte;
        logic [7:0] data_v;
        logic       pay_last;
        n_phase       = r_phase;
        n_field_count = r_field_count;
        n_length_acc  = r_length_acc;
        n_key_store   = r_key_store;
        n_remaining   = r_remaining;
        n_key_index   = r_key_index;
        n_fin         = r_fin;
        n_rsv         = r_rsv;
        n_opcode      = r_opcode;
        n_masked      = r_masked;
        do_after      = 1'b0;
        do_hdr        = 1'b0;
        data_v        = '0;
        pay_last      = 1'b0;
        o_res_vld     = 1'b0;
        o_res         = '0;

        case (r_key_index)
            2'd0:    key_byte = r_key_store[31:24];
            2'd1:    key_byte = r_key_store[23:16];
            2'd2:    key_byte = r_key_store[15:8];
            default: key_byte = r_key_store[7:0];
        endcase

        if (i_step) begin
            unique case (r_phase)
                wsfd_pkg::PH_HDR1: begin
                    n_masked     = i_byte[7];
                    n_length_acc = '0;
                    if (i_byte[6:0] == wsfd_pkg::LenExt16) begin
                        n_field_count = wsfd_pkg::FieldsExt16;
                        n_phase       = wsfd_pkg::PH_EXTLEN;
                    end else if (i_byte[6:0] == wsfd_pkg::LenExt64) begin
                        n_field_count = wsfd_pkg::FieldsExt64;
                        n_phase       = wsfd_pkg::PH_EXTLEN;
                    end else begin
                        n_length_acc = {57'd0, i_byte[6:0]};
                        do_after     = 1'b1;
                    end
                end
                wsfd_pkg::PH_EXTLEN: begin
                    n_length_acc  = {r_length_acc[55:0], i_byte};
                    n_field_count = r_field_count - 4'd1;
                    do_after      = (n_field_count == 4'd0);
                end
                wsfd_pkg::PH_KEY: begin
                    n_key_store   = {r_key_store[23:0], i_byte};
                    n_field_count = r_field_count - 4'd1;
                    do_hdr        = (n_field_count == 4'd0);
                end
                wsfd_pkg::PH_PAYLOAD: begin
                    data_v      = i_byte ^ (r_masked ? key_byte : 8'd0);
                    n_key_index = r_key_index + 2'd1;
                    n_remaining = r_remaining - 64'd1;
                    pay_last    = (r_remaining == 64'd1);
                    if (pay_last) begin
                        n_phase = wsfd_pkg::PH_HDR0;
                    end
                    o_res_vld = 1'b1;
                end
                default: begin
                    n_fin    = i_byte[7];
                    n_rsv    = i_byte[6:4];
                    n_opcode = i_byte[3:0];
                    n_phase  = wsfd_pkg::PH_HDR1;
                end
            endcase

            if (do_after) begin
                if (n_masked) begin
                    n_field_count = wsfd_pkg::FieldsKey;
                    n_key_store   = '0;
                    n_phase       = wsfd_pkg::PH_KEY;
                end else begin
                    do_hdr = 1'b1;
                end
            end

            if (do_hdr) begin
                n_remaining = n_length_acc;
                n_key_index = '0;
                pay_last    = (n_length_acc == 64'd0);
                n_phase     = pay_last ? wsfd_pkg::PH_HDR0 : wsfd_pkg::PH_PAYLOAD;
                o_res_vld   = 1'b1;
            end
        end

        o_res.kind         = do_hdr ? wsfd_pkg::KindHeader : wsfd_pkg::KindPayload;
        o_res.data_out     = data_v;
        o_res.fin          = n_fin;
        o_res.rsv_bits     = n_rsv;
        o_res.opcode       = n_opcode;
        o_res.masked       = n_masked;
        o_res.frame_length = n_length_acc;
        o_res.last         = pay_last;
    end

    `WSFD_ASSERT_NOW(a_payload_in_phase, i_clk, i_rst_n,
        i_step && o_res_vld && o_res.kind == wsfd_pkg::KindPayload,
        r_phase == wsfd_pkg::PH_PAYLOAD, "payload result outside payload phase")
    `WSFD_ASSERT_NEXT(a_last_to_hdr0, i_clk, i_rst_n,
        i_step && o_res_vld && o_res.last,
        r_phase == wsfd_pkg::PH_HDR0, "frame end did not return to first header byte")
    `WSFD_ASSERT_NEXT(a_hdr_to_payload, i_clk, i_rst_n,
        i_step && o_res_vld && o_res.kind == wsfd_pkg::KindHeader && !o_res.last,
        r_phase == wsfd_pkg::PH_PAYLOAD && r_key_index == 2'd0, "header did not open payload")
    `WSFD_ASSERT_NOW(a_key_count, i_clk, i_rst_n,
        r_phase == wsfd_pkg::PH_KEY,
        r_field_count != 4'd0 && r_field_count <= wsfd_pkg::FieldsKey,
        "key byte count out of range")

endmodule

/* rtl/wsfd_out_stage.sv */
`timescale 1ns / 1ps

module wsfd_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_res_vld,
    input  wsfd_pkg::t_result i_res,
    input  logic              i_ready,
    output logic              o_free,
    output logic              o_valid,
    output wsfd_pkg::t_result o_res
);

    logic              r_vld;
    wsfd_pkg::t_result r_res;

    assign o_free  = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= i_res_vld;
        end else if (i_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_res_vld) begin
            r_res <= i_res;
        end
    end

endmodule

/* rtl/websocket_frame_decoder.sv */
// Path: a byte taken into the input register is parsed and unmasked into the result
// register once that register is free, and its result then transfers out from there.
// Throughput: one byte per cycle while the result register is free; it frees on transfer.
// Reset: synchronous active-low i_rst_n empties both registers and returns the
// parser to the first header byte with all frame state cleared.
`timescale 1ns / 1ps

module websocket_frame_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output logic [7:0]  o_data_out,
    output logic        o_fin,
    output logic [2:0]  o_rsv_bits,
    output logic [3:0]  o_opcode,
    output logic        o_masked,
    output logic [63:0] o_frame_length,
    output logic        o_last
);

    logic              r_in_vld;
    logic [7:0]        r_in_byte;
    logic              out_free;
    logic              step;
    logic              res_vld;
    wsfd_pkg::t_result res;
    wsfd_pkg::t_result out_res;

    assign step    = r_in_vld && out_free;
    assign o_ready = !r_in_vld || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_data_byte;
        end
    end

    wsfd_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_byte    (r_in_byte),
        .o_res_vld (res_vld),
        .o_res     (res)
    );

    wsfd_out_stage u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (step),
        .i_res_vld (res_vld),
        .i_res     (res),
        .i_ready   (i_ready),
        .o_free    (out_free),
        .o_valid   (o_valid),
        .o_res     (out_res)
    );

    assign o_kind         = out_res.kind;
    assign o_data_out     = out_res.data_out;
    assign o_fin          = out_res.fin;
    assign o_rsv_bits     = out_res.rsv_bits;
    assign o_opcode       = out_res.opcode;
    assign o_masked       = out_res.masked;
    assign o_frame_length = out_res.frame_length;
    assign o_last         = out_res.last;

endmodule
